FILE: hdl/asc_pkg.sv
// ----------------------------------------------------------------------------
// asc_pkg
// Shared types and constants for the accelerometer step counter: sequencer
// states, detector phases, register indexes and configuration fields.
// ----------------------------------------------------------------------------
package asc_pkg;

  // field widths
  localparam int AXIS_W = 10;
  localparam int MAG_W  = 11;
  localparam int SUM_W  = 22;
  localparam int ACC_W  = 23;
  localparam int CNT_W  = 4;

  // constants of the detector and the average
  localparam logic [CNT_W-1:0]  CNT_MAX        = 4'd15;
  localparam logic [AXIS_W-1:0] ALPHA_FULL     = 10'd1023;
  localparam logic [MAG_W-1:0]  LOCAL_MIN_INIT = 11'd1024;

  // register reset values
  localparam logic [9:0] ALPHA_RST        = 10'd128;
  localparam logic [3:0] COUNT_TARGET_RST = 4'd5;
  localparam logic [7:0] OVERSHOOT_RST    = 8'd25;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_ALPHA        = 2'd0;
  localparam logic [1:0] REG_COUNT_TARGET = 2'd1;
  localparam logic [1:0] REG_OVERSHOOT    = 2'd2;

  typedef struct packed {
    logic [9:0] alpha;
    logic [3:0] count_target;
    logic [7:0] overshoot;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_AVG_A,
    ST_AVG_B,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    PH_SEEK_MAX  = 2'd0,
    PH_SEEK_LOW  = 2'd1,
    PH_SEEK_MIN  = 2'd2,
    PH_SEEK_HIGH = 2'd3
  } phase_t;

endpackage

FILE: hdl/asc_cfg.sv
// ----------------------------------------------------------------------------
// asc_cfg
// APB register bank holding alpha, count_target and overshoot.
// ----------------------------------------------------------------------------
module asc_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output asc_pkg::cfg_t       cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha        <= asc_pkg::ALPHA_RST;
      cfg.count_target <= asc_pkg::COUNT_TARGET_RST;
      cfg.overshoot    <= asc_pkg::OVERSHOOT_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        asc_pkg::REG_ALPHA:        cfg.alpha        <= pwdata[9:0];
        asc_pkg::REG_COUNT_TARGET: cfg.count_target <= pwdata[3:0];
        asc_pkg::REG_OVERSHOOT:    cfg.overshoot    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (paddr[3:2])
      asc_pkg::REG_ALPHA:        prdata = {22'd0, cfg.alpha};
      asc_pkg::REG_COUNT_TARGET: prdata = {28'd0, cfg.count_target};
      asc_pkg::REG_OVERSHOOT:    prdata = {24'd0, cfg.overshoot};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

FILE: hdl/asc_mac.sv
// ----------------------------------------------------------------------------
// asc_mac
// Shared multiply-accumulate unit: one 11x11 product per cycle while enabled, into a
// registered accumulator. Serves the squares and the average update.
// ----------------------------------------------------------------------------
module asc_mac (
  input  logic                        clk,
  input  logic                        en,
  input  logic                        clr,
  input  logic [asc_pkg::MAG_W-1:0]   op_a,
  input  logic [asc_pkg::MAG_W-1:0]   op_b,
  output logic [asc_pkg::ACC_W-1:0]   acc
);

  logic [asc_pkg::SUM_W-1:0] prod;
  logic [asc_pkg::ACC_W-1:0] base;

  assign prod = asc_pkg::SUM_W'(op_a) * asc_pkg::SUM_W'(op_b);
  assign base = clr ? '0 : acc;

  // accumulate, or restart from the product
  always_ff @(posedge clk) begin
    if (en) begin
      acc <= base + asc_pkg::ACC_W'(prod);
    end
  end

endmodule

FILE: hdl/asc_isqrt.sv
// ----------------------------------------------------------------------------
// asc_isqrt
// Digit-by-digit integer square root of a 22-bit value, one result bit per
// cycle, then a one-cycle done pulse.
// ----------------------------------------------------------------------------
module asc_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [asc_pkg::SUM_W-1:0]   value,
  output logic [asc_pkg::MAG_W-1:0]   root,
  output logic                        done
);

  localparam logic [3:0] LAST_STEP = 4'(asc_pkg::MAG_W - 1);

  logic [asc_pkg::SUM_W-1:0] sh;
  logic [13:0]               rem;
  logic [3:0]                step;
  logic                      busy;
  logic [13:0]               rem_sh;
  logic [13:0]               trial;
  logic                      ge;

  // bring down two bits, try root*4+1
  assign rem_sh = {rem[11:0], sh[asc_pkg::SUM_W-1 -: 2]};
  assign trial  = {2'b00, root[9:0], 2'b01};
  assign ge     = rem_sh >= trial;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 4'd1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      sh   <= value;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      sh   <= {sh[asc_pkg::SUM_W-3:0], 2'b00};
      rem  <= ge ? (rem_sh - trial) : rem_sh;
      root <= {root[9:0], ge};
    end
  end

endmodule

FILE: hdl/accel_step_counter.sv
// ----------------------------------------------------------------------------
// accel_step_counter
// Peak/valley pedometer: magnitude of a three-axis sample by a shared MAC and
// an iterative square root, moving average, four-phase step detector.
// ----------------------------------------------------------------------------
// One sample at a time: a new sample is accepted only in the idle state, after the
//   11-step square root and the five passes through the single multiply-accumulate
//   unit for the sample before it are done.
// A finished result waits in the output register while the next item is
//   taken; the block stalls only in its finish state if that register is full.
// Reset (rst, synchronous): defaults, seek maximum, zero count; first sample seeds the average.
module accel_step_counter (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // sample in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // accel_x[9:0], accel_y[19:10], accel_z[29:20]
  // result out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // magnitude[10:0], average[21:11], step_seen[22],
                                     // step_count[54:23], phase[56:55]
);

  localparam int MW = asc_pkg::MAG_W;

  asc_pkg::cfg_t   cfg;
  asc_pkg::state_t state, state_next;
  asc_pkg::phase_t phase, phase_next;

  logic [asc_pkg::AXIS_W-1:0] accel_x, accel_y, accel_z;
  logic                       primed;
  logic [MW-1:0]              avg_reg;
  logic [MW-1:0]              local_max, local_max_next;
  logic [MW-1:0]              local_min, local_min_next;
  logic [asc_pkg::CNT_W-1:0]  confirm_count, confirm_count_next;
  logic [31:0]                step_total;

  logic                       in_acc;
  logic                       slot_free;
  logic                       commit;
  logic                       mac_en, mac_clr, root_start;
  logic [MW-1:0]              mac_a, mac_b;
  logic [asc_pkg::ACC_W-1:0]  acc;
  logic [MW-1:0]              mag;
  logic                       root_done;
  logic [MW-1:0]              new_avg;
  logic [asc_pkg::CNT_W-1:0]  cnt_bumped;
  logic                       confirmed;
  logic                       low_hit, high_hit;
  logic                       seen;

  asc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  asc_mac u_mac (
    .clk  (clk),
    .en   (mac_en),
    .clr  (mac_clr),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (acc)
  );

  asc_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .value (acc[asc_pkg::SUM_W-1:0]),
    .root  (mag),
    .done  (root_done)
  );

  assign s_axis_tready = (state == asc_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !m_axis_tvalid || m_axis_tready;
  assign commit        = (state == asc_pkg::ST_FINISH) && slot_free;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      asc_pkg::ST_IDLE:      if (in_acc) state_next = asc_pkg::ST_SQ_X;
      asc_pkg::ST_SQ_X:      state_next = asc_pkg::ST_SQ_Y;
      asc_pkg::ST_SQ_Y:      state_next = asc_pkg::ST_SQ_Z;
      asc_pkg::ST_SQ_Z:      state_next = asc_pkg::ST_ROOT_GO;
      asc_pkg::ST_ROOT_GO:   state_next = asc_pkg::ST_ROOT_WAIT;
      asc_pkg::ST_ROOT_WAIT: if (root_done) state_next = asc_pkg::ST_AVG_A;
      asc_pkg::ST_AVG_A:     state_next = asc_pkg::ST_AVG_B;
      asc_pkg::ST_AVG_B:     state_next = asc_pkg::ST_FINISH;
      asc_pkg::ST_FINISH:    if (slot_free) state_next = asc_pkg::ST_IDLE;
      default:               state_next = asc_pkg::ST_IDLE;
    endcase
  end

  // drive the shared units
  always_comb begin
    mac_en     = 1'b0;
    mac_clr    = 1'b0;
    mac_a      = '0;
    mac_b      = '0;
    root_start = 1'b0;
    unique case (state)
      asc_pkg::ST_SQ_X: begin
        mac_en  = 1'b1;
        mac_clr = 1'b1;
        mac_a   = MW'(accel_x);
        mac_b   = MW'(accel_x);
      end
      asc_pkg::ST_SQ_Y: begin
        mac_en = 1'b1;
        mac_a  = MW'(accel_y);
        mac_b  = MW'(accel_y);
      end
      asc_pkg::ST_SQ_Z: begin
        mac_en = 1'b1;
        mac_a  = MW'(accel_z);
        mac_b  = MW'(accel_z);
      end
      asc_pkg::ST_ROOT_GO: root_start = 1'b1;
      asc_pkg::ST_AVG_A: begin
        mac_en  = 1'b1;
        mac_clr = 1'b1;
        mac_a   = MW'(cfg.alpha);
        mac_b   = mag;
      end
      asc_pkg::ST_AVG_B: begin
        mac_en = 1'b1;
        mac_a  = MW'(asc_pkg::ALPHA_FULL - cfg.alpha);
        mac_b  = avg_reg;
      end
      default: ;
    endcase
  end

  // average and crossing tests
  assign new_avg    = primed ? acc[MW+9:10] : mag;
  assign cnt_bumped = (confirm_count < asc_pkg::CNT_MAX) ? confirm_count + 4'd1 : confirm_count;
  assign confirmed  = cnt_bumped >= cfg.count_target;
  assign low_hit    = (new_avg < MW'(cfg.overshoot)) || (mag < new_avg - MW'(cfg.overshoot));
  assign high_hit   = (12'(mag) > 12'(new_avg) + 12'(cfg.overshoot));

  // detector next values
  always_comb begin
    phase_next         = phase;
    local_max_next     = local_max;
    local_min_next     = local_min;
    confirm_count_next = confirm_count;
    seen               = 1'b0;
    if (primed) begin
      unique case (phase)
        asc_pkg::PH_SEEK_MAX: begin
          if (mag > local_max) begin
            local_max_next     = mag;
            confirm_count_next = '0;
          end else begin
            confirm_count_next = cnt_bumped;
            if (confirmed) phase_next = asc_pkg::PH_SEEK_LOW;
          end
        end
        asc_pkg::PH_SEEK_LOW: begin
          if (mag > local_max) begin
            local_max_next     = mag;
            confirm_count_next = '0;
            phase_next         = asc_pkg::PH_SEEK_MAX;
          end else if (low_hit) begin
            seen               = 1'b1;
            local_min_next     = asc_pkg::LOCAL_MIN_INIT;
            confirm_count_next = '0;
            phase_next         = asc_pkg::PH_SEEK_MIN;
          end
        end
        asc_pkg::PH_SEEK_MIN: begin
          if (mag < local_min) begin
            local_min_next     = mag;
            confirm_count_next = '0;
          end else begin
            confirm_count_next = cnt_bumped;
            if (confirmed) phase_next = asc_pkg::PH_SEEK_HIGH;
          end
        end
        default: begin
          if (mag < local_min) begin
            local_min_next     = mag;
            confirm_count_next = '0;
            phase_next         = asc_pkg::PH_SEEK_MIN;
          end else if (high_hit) begin
            seen               = 1'b1;
            local_max_next     = '0;
            confirm_count_next = '0;
            phase_next         = asc_pkg::PH_SEEK_MAX;
          end
        end
      endcase
    end
  end

  // sequencer and detector state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= asc_pkg::ST_IDLE;
      phase         <= asc_pkg::PH_SEEK_MAX;
      primed        <= 1'b0;
      avg_reg       <= '0;
      local_max     <= '0;
      local_min     <= asc_pkg::LOCAL_MIN_INIT;
      confirm_count <= '0;
      step_total    <= '0;
    end else begin
      state <= state_next;
      if (commit) begin
        phase         <= phase_next;
        primed        <= 1'b1;
        avg_reg       <= new_avg;
        local_max     <= local_max_next;
        local_min     <= local_min_next;
        confirm_count <= confirm_count_next;
        step_total    <= step_total + 32'(seen);
      end
    end
  end

  // latch the sample
  always_ff @(posedge clk) begin
    if (in_acc) begin
      accel_x <= s_axis_tdata[9:0];
      accel_y <= s_axis_tdata[19:10];
      accel_z <= s_axis_tdata[29:20];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (commit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_axis_tdata <= {7'd0, phase_next, step_total + 32'(seen), seen, new_avg, mag};
    end
  end

`ifndef SYNTH
  // a step bumps the count by exactly one
  a_step_count: assert property (@(posedge clk) disable iff (rst)
    commit && seen |=> step_total == $past(step_total) + 32'd1)
    else $error("step count did not advance on a step");

  // once primed, stay primed until reset
  a_primed_holds: assert property (@(posedge clk) disable iff (rst)
    primed |=> primed)
    else $error("primed dropped without reset");

  // a step is only reported on entering seek-min or seek-max
  a_step_phase: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[22] |->
      (m_axis_tdata[56:55] == asc_pkg::PH_SEEK_MAX) ||
      (m_axis_tdata[56:55] == asc_pkg::PH_SEEK_MIN))
    else $error("step reported in a crossing phase");

  // the root is exact
  a_root_exact: assert property (@(posedge clk) disable iff (rst)
    root_done |-> (24'(mag) * 24'(mag) <= 24'(acc[asc_pkg::SUM_W-1:0])) &&
                  ((24'(mag) + 24'd1) * (24'(mag) + 24'd1) > 24'(acc[asc_pkg::SUM_W-1:0])))
    else $error("square root not exact");
`endif

endmodule
